### rtl/assert_macros.svh
// Assertion macros shared by the queue and back end modules of the PTP slave offset and delay unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define PSOD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, forces another one at the next clock edge.
`define PSOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ptp_sod_pkg.sv
// Types, codes and arithmetic helpers of the PTP slave offset and delay unit.
`default_nettype none

package ptp_sod_pkg;

    // Message action codes on the input channel.
    localparam logic [1:0] ACT_SYNC       = 2'd0;
    localparam logic [1:0] ACT_FOLLOW_UP  = 2'd1;
    localparam logic [1:0] ACT_DELAY_RESP = 2'd2;
    localparam logic [1:0] ACT_TX_TS      = 2'd3;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // Input beat.
    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        msg_seq;
        logic               hw_ts_present;
        logic [31:0]        hw_seconds;
        logic [29:0]        hw_nanoseconds;
        logic [31:0]        msg_seconds;
        logic [29:0]        msg_nanoseconds;
        logic signed [63:0] correction;
        logic               two_step;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic               send_delay_req;
        logic [15:0]        delay_req_seq;
        logic               update_valid;
        logic signed [63:0] offset_ns;
        logic signed [63:0] one_way_delay_ns;
    } result_t;

    // Work kinds that the front end hands to the back end.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SYNC_TWO,
        CMD_SYNC_ONE,
        CMD_FOLLOW,
        CMD_TX_TS,
        CMD_RESP
    } cmd_kind_t;

    // Classified command with both timestamps already in nanoseconds.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] seq;
        logic [63:0] hw_time;
        logic [63:0] msg_time;
        logic [63:0] corr;
    } cmd_t;

    // Seconds and nanoseconds to a nanosecond count.
    function automatic logic [63:0] to_ns(input logic [31:0] sec, input logic [29:0] nsec);
        logic [61:0] prod;
        prod = {30'd0, sec} * {32'd0, NS_PER_SEC};
        return {2'b00, prod} + {34'd0, nsec};
    endfunction

    // Correction field to whole nanoseconds (arithmetic shift right by 16).
    function automatic logic [63:0] corr_to_ns(input logic [63:0] v);
        return {{16{v[63]}}, v[63:16]};
    endfunction

    // Signed halving that truncates toward zero.
    function automatic logic [63:0] half_to_zero(input logic [63:0] v);
        logic [63:0] biased;
        biased = v + {63'd0, v[63]};
        return {biased[63], biased[63:1]};
    endfunction

endpackage

`default_nettype wire

### rtl/ptp_sod_fifo.sv
// Small synchronous first-in first-out queue built from registers.
`default_nettype none

`include "assert_macros.svh"

module ptp_sod_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; occupancy tells which entries hold data.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `PSOD_ASSERT_ALWAYS(a_count_bound, count_reg <= CntW'(DEPTH), "fifo occupancy over depth")
    `PSOD_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "fifo push lost")

endmodule

`default_nettype wire

### rtl/ptp_sod_front.sv
// Front end: takes input beats, converts timestamps to nanoseconds and classifies them.
`default_nettype none

module ptp_sod_front
    import ptp_sod_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       cmd_push,
    output cmd_t       cmd,
    input  wire logic  cmd_full
);

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  take;

    // One input register; it frees up whenever the command queue has room.
    assign full     = in_valid_reg && cmd_full;
    assign take     = push && !full;
    assign cmd_push = in_valid_reg;

    always_comb
    begin
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (cmd_full)
        begin
            in_valid_next = in_valid_reg;
        end
        else
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item;
        end
    end

    // Classification of the held beat into a command for the back end.
    always_comb
    begin
        cmd.seq      = in_item_reg.msg_seq;
        cmd.hw_time  = to_ns(in_item_reg.hw_seconds, in_item_reg.hw_nanoseconds);
        cmd.msg_time = to_ns(in_item_reg.msg_seconds, in_item_reg.msg_nanoseconds);
        cmd.corr     = in_item_reg.correction;
        case (in_item_reg.action)
            ACT_SYNC:
            begin
                if (!in_item_reg.hw_ts_present)
                begin
                    cmd.kind = CMD_NONE;
                end
                else if (in_item_reg.two_step)
                begin
                    cmd.kind = CMD_SYNC_TWO;
                end
                else
                begin
                    cmd.kind = CMD_SYNC_ONE;
                end
            end
            ACT_FOLLOW_UP:  cmd.kind = CMD_FOLLOW;
            ACT_DELAY_RESP: cmd.kind = CMD_RESP;
            ACT_TX_TS:      cmd.kind = CMD_TX_TS;
            default:        cmd.kind = CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ptp_sod_back.sv
// Back end: exchange state, offset and delay arithmetic pipeline.
`default_nettype none

`include "assert_macros.svh"

module ptp_sod_back
    import ptp_sod_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  cmd,
    input  wire logic  cmd_empty,
    output logic       cmd_pop,
    output logic       res_push,
    output result_t    res,
    input  wire logic  res_full
);

    // Tag that rides along with every beat through the pipeline.
    typedef struct packed {
        logic        send;
        logic [15:0] seq;
        logic        resp;
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c1;
        logic [63:0] c4;
    } st1_t;

    typedef struct packed {
        tag_t        tag;
        logic [63:0] x;
        logic [63:0] y;
    } st2_t;

    // Exchange state.
    logic [63:0] origin_reg, origin_next;
    logic [63:0] sync_rx_reg, sync_rx_next;
    logic [63:0] req_tx_reg, req_tx_next;
    logic [63:0] sync_corr_reg, sync_corr_next;
    logic [15:0] exp_seq_reg, exp_seq_next;
    logic [15:0] req_seq_reg, req_seq_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st2_t s3_reg, s3_next;
    logic adv;
    logic [15:0] seq_inc;

    // The whole pipeline moves unless the last stage is blocked by the result queue.
    assign adv      = !(s3_valid_reg && res_full);
    assign cmd_pop  = adv && !cmd_empty;
    assign seq_inc  = req_seq_reg + 16'd1;

    // Stage one: apply the command to the state and snapshot the operands.
    always_comb
    begin
        origin_next    = origin_reg;
        sync_rx_next   = sync_rx_reg;
        req_tx_next    = req_tx_reg;
        sync_corr_next = sync_corr_reg;
        exp_seq_next   = exp_seq_reg;
        req_seq_next   = req_seq_reg;
        s1_next.tag.send = 1'b0;
        s1_next.tag.seq  = 16'd0;
        s1_next.tag.resp = 1'b0;
        s1_next.a  = sync_rx_reg - origin_reg;
        s1_next.b  = cmd.msg_time - req_tx_reg;
        s1_next.c1 = corr_to_ns(sync_corr_reg);
        s1_next.c4 = corr_to_ns(cmd.corr);
        case (cmd.kind)
            CMD_SYNC_TWO:
            begin
                sync_rx_next   = cmd.hw_time;
                sync_corr_next = cmd.corr;
                exp_seq_next   = cmd.seq;
            end
            CMD_SYNC_ONE:
            begin
                sync_rx_next   = cmd.hw_time;
                sync_corr_next = cmd.corr;
                exp_seq_next   = cmd.seq;
                origin_next    = cmd.msg_time;
                req_seq_next   = seq_inc;
                s1_next.tag.send = 1'b1;
                s1_next.tag.seq  = seq_inc;
            end
            CMD_FOLLOW:
            begin
                if (cmd.seq == exp_seq_reg)
                begin
                    origin_next    = cmd.msg_time;
                    sync_corr_next = sync_corr_reg + cmd.corr;
                    req_seq_next   = seq_inc;
                    s1_next.tag.send = 1'b1;
                    s1_next.tag.seq  = seq_inc;
                end
            end
            CMD_TX_TS:
            begin
                if (cmd.seq == req_seq_reg)
                begin
                    req_tx_next = cmd.hw_time;
                end
            end
            CMD_RESP:
            begin
                s1_next.tag.resp = 1'b1;
            end
            default:
            begin
                s1_next.tag.resp = 1'b0;
            end
        endcase
    end

    // Stage two: both one-way differences less their corrections.
    always_comb
    begin
        s2_next.tag = s1_reg.tag;
        s2_next.x   = s1_reg.a - s1_reg.c1;
        s2_next.y   = s1_reg.b - s1_reg.c4;
    end

    // Stage three: difference and sum of the two directions.
    always_comb
    begin
        s3_next.tag = s2_reg.tag;
        s3_next.x   = s2_reg.y - s2_reg.x;
        s3_next.y   = s2_reg.y + s2_reg.x;
    end

    // Last step: halve and form the result beat.
    assign res_push = s3_valid_reg && !res_full;

    always_comb
    begin
        res.send_delay_req = s3_reg.tag.send;
        res.delay_req_seq  = s3_reg.tag.seq;
        res.update_valid   = s3_reg.tag.resp;
        res.offset_ns        = s3_reg.tag.resp ? half_to_zero(s3_reg.x) : 64'd0;
        res.one_way_delay_ns = s3_reg.tag.resp ? half_to_zero(s3_reg.y) : 64'd0;
    end

    // State and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg    <= '0;
            sync_rx_reg   <= '0;
            req_tx_reg    <= '0;
            sync_corr_reg <= '0;
            exp_seq_reg   <= '0;
            req_seq_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                origin_reg    <= origin_next;
                sync_rx_reg   <= sync_rx_next;
                req_tx_reg    <= req_tx_next;
                sync_corr_reg <= sync_corr_next;
                exp_seq_reg   <= exp_seq_next;
                req_seq_reg   <= req_seq_next;
            end
            if (adv)
            begin
                s1_valid_reg <= !cmd_empty;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    `PSOD_ASSERT_NEXT(a_stall_hold, s3_valid_reg && res_full, s3_valid_reg && $stable(s3_reg), "stalled result beat changed")
    `PSOD_ASSERT_ALWAYS(a_seq_track, !(s1_valid_reg && s1_reg.tag.send) || (s1_reg.tag.seq == req_seq_reg), "request sequence out of step")
    `PSOD_ASSERT_ALWAYS(a_one_kind, !(s1_reg.tag.send && s1_reg.tag.resp) || !s1_valid_reg, "request and update in one beat")

endmodule

`default_nettype wire

### rtl/ptp_slave_offset_delay_unit.sv
// PTPv2 slave end-to-end exchange: offset and mean path delay from decoded message events.
//
// Input channel: a beat (item) is taken at a clock edge with push high and full low. Each beat
// is one decoded event: Sync, Follow_Up, Delay_Resp or a Delay_Req transmit timestamp report.
// Result channel: exactly one result beat per input beat, in input order. The oldest result is
// on the result port while empty is low and leaves at an edge with pop high.
// A result carries send_delay_req with its new sequence number when a Delay_Req is due, and
// update_valid with offset_ns and one_way_delay_ns after a Delay_Resp; unused fields are zero.
// Path: a result reaches the result port through the input register with the timestamp
// multipliers, loaded at the edge that takes its input beat, then the command queue, three
// arithmetic stages and the result queue.
// Throughput: one beat per cycle unless the result queue fills; every stage is a plain
// register and the exchange state changes per popped command, so beats follow back to back.
// Stalls: when pop stays low the result queue fills, the back end pipeline holds, the command
// queue fills and full rises; nothing is dropped and beats resume where they stopped.
// Reset: rst_n clears all queues and the exchange state (times, corrections, sequence numbers)
// to zero; full is low out of reset, so the block takes beats as soon as rst_n is released.
`default_nettype none

module ptp_slave_offset_delay_unit
    import ptp_sod_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    cmd_t                 front_cmd;
    logic                 front_push;
    logic                 cmdq_full;
    logic                 cmdq_empty;
    logic                 cmdq_pop;
    logic [$bits(cmd_t)-1:0] cmdq_rdata;
    result_t              back_res;
    logic                 back_push;
    logic                 resq_full;
    logic [$bits(result_t)-1:0] resq_rdata;

    ptp_sod_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (front_push),
        .cmd      (front_cmd),
        .cmd_full (cmdq_full)
    );

    ptp_sod_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .full  (cmdq_full),
        .pop   (cmdq_pop),
        .rdata (cmdq_rdata),
        .empty (cmdq_empty)
    );

    ptp_sod_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_t'(cmdq_rdata)),
        .cmd_empty (cmdq_empty),
        .cmd_pop   (cmdq_pop),
        .res_push  (back_push),
        .res       (back_res),
        .res_full  (resq_full)
    );

    ptp_sod_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .wdata (back_res),
        .full  (resq_full),
        .pop   (pop),
        .rdata (resq_rdata),
        .empty (empty)
    );

    assign result = result_t'(resq_rdata);

endmodule

`default_nettype wire

### test/ptp_slave_offset_delay_unit_tb.sv
// Self-checking testbench for the PTP slave offset and delay unit: directed and random traffic.
module ptp_slave_offset_delay_unit_tb
    import ptp_sod_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {PACE_RANDOM, PACE_EAGER} pace_t;

    localparam int RANDOM_ITEMS   = 1240;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    // Exchange state as the slave should hold it.
    logic [63:0] t1_origin;
    logic [63:0] t2_sync_rx;
    logic [63:0] t3_req_tx;
    logic [63:0] t4_resp;
    logic [63:0] sync_corr_acc;
    logic [63:0] resp_corr_val;
    logic [15:0] sync_seq_held;
    logic [15:0] dreq_seq_held;

    result_t predicted_results[$];

    pace_t tx_pace = PACE_RANDOM;
    pace_t rx_pace = PACE_RANDOM;
    bit    hold_request = 1'b0;

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int updates_seen = 0;
    int delay_reqs_seen = 0;
    int idle_cycles = 0;

    ptp_slave_offset_delay_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    // Seconds and nanoseconds folded into one nanosecond count.
    function automatic logic [63:0] stamp_ns(input logic [31:0] sec, input logic [29:0] nsec);
        return {32'd0, sec} * NS_PER_SECOND + {34'd0, nsec};
    endfunction

    // Scaled correction to whole nanoseconds, rounding toward minus infinity.
    function automatic logic [63:0] corr_whole_ns(input logic [63:0] v);
        logic signed [63:0] sv;
        sv = v;
        return sv >>> 16;
    endfunction

    // Signed halving; SystemVerilog division already truncates toward zero.
    function automatic logic [63:0] halve(input logic [63:0] v);
        logic signed [63:0] sv;
        sv = v;
        return sv / 64'sd2;
    endfunction

    // Advances the exchange state by one event and returns the result beat it should cause.
    function automatic result_t predict_exchange(input item_t it);
        result_t     r;
        logic [63:0] corr;
        logic [63:0] d_ms;
        logic [63:0] d_sm;
        logic        origin_due;
        r = '0;
        corr = it.correction;
        origin_due = 1'b0;
        case (it.action)
            ACT_SYNC:
            begin
                if (!it.hw_ts_present)
                begin
                    return r;
                end
                t2_sync_rx = stamp_ns(it.hw_seconds, it.hw_nanoseconds);
                sync_corr_acc = corr;
                sync_seq_held = it.msg_seq;
                if (it.two_step)
                begin
                    return r;
                end
                // One-step: the correction was taken above, so do not add it twice.
                corr = '0;
                origin_due = 1'b1;
            end
            ACT_FOLLOW_UP:
            begin
                origin_due = 1'b1;
            end
            ACT_TX_TS:
            begin
                if (it.msg_seq == dreq_seq_held)
                begin
                    t3_req_tx = stamp_ns(it.hw_seconds, it.hw_nanoseconds);
                end
                return r;
            end
            default:
            begin
                // Delay response closes the exchange with whatever t1..t3 are held.
                t4_resp = stamp_ns(it.msg_seconds, it.msg_nanoseconds);
                resp_corr_val = corr;
                d_ms = t2_sync_rx - t1_origin - corr_whole_ns(sync_corr_acc);
                d_sm = t4_resp - t3_req_tx - corr_whole_ns(resp_corr_val);
                r.update_valid = 1'b1;
                r.offset_ns = halve(d_sm - d_ms);
                r.one_way_delay_ns = halve(d_sm + d_ms);
                return r;
            end
        endcase
        if (origin_due && it.msg_seq == sync_seq_held)
        begin
            t1_origin = stamp_ns(it.msg_seconds, it.msg_nanoseconds);
            sync_corr_acc = sync_corr_acc + corr;
            dreq_seq_held = dreq_seq_held + 16'd1;
            r.send_delay_req = 1'b1;
            r.delay_req_seq = dreq_seq_held;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_sec();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            return 32'd0;
        end
        if (roll == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    function automatic logic [29:0] rand_nsec();
        int unsigned roll;
        roll = $urandom_range(0, 24);
        if (roll < 2)
        begin
            return 30'($urandom_range(1000000000, 30'h3FFF_FFFF));
        end
        if (roll == 2)
        begin
            return 30'd0;
        end
        if (roll == 3)
        begin
            return 30'd999999999;
        end
        return 30'($urandom_range(0, 999999999));
    endfunction

    function automatic logic [63:0] rand_corr();
        logic signed [31:0] near;
        int unsigned        roll;
        roll = $urandom_range(0, 9);
        near = $urandom;
        if (roll < 2)
        begin
            return 64'd0;
        end
        if (roll < 6)
        begin
            return 64'(near);
        end
        return {$urandom, $urandom};
    endfunction

    function automatic item_t make_item(input logic [1:0] action, input logic [15:0] seq,
                                        input logic hw_present, input logic [31:0] hw_sec,
                                        input logic [29:0] hw_nsec, input logic [31:0] msg_sec,
                                        input logic [29:0] msg_nsec, input logic [63:0] corr,
                                        input logic two_step);
        item_t it;
        it.action = action;
        it.msg_seq = seq;
        it.hw_ts_present = hw_present;
        it.hw_seconds = hw_sec;
        it.hw_nanoseconds = hw_nsec;
        it.msg_seconds = msg_sec;
        it.msg_nanoseconds = msg_nsec;
        it.correction = corr;
        it.two_step = two_step;
        return it;
    endfunction

    // Event of the given kind with every other field random.
    function automatic item_t rand_item(input logic [1:0] action, input logic [15:0] seq);
        return make_item(action, seq, 1'($urandom), rand_sec(), rand_nsec(), rand_sec(),
                         rand_nsec(), rand_corr(), 1'($urandom));
    endfunction

    // Offers one beat, waits until it is taken and records the result it should cause.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = (tx_pace == PACE_EAGER) ? 0 : pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predicted_results.push_back(predict_exchange(it));
        items_sent++;
    endtask

    // Stops offering beats until every predicted result has been taken.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One full exchange with random content and occasional breaks in the sequence.
    task automatic send_exchange();
        logic [15:0] seq;
        item_t       it;
        logic        two;
        seq = 16'($urandom);
        two = 1'($urandom_range(0, 1));
        it = rand_item(ACT_SYNC, seq);
        it.two_step = two;
        it.hw_ts_present = ($urandom_range(0, 19) != 0);
        send_item(it);
        if (two)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(rand_item(ACT_FOLLOW_UP, seq + 16'($urandom_range(1, 65535))));
            end
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(rand_item(ACT_FOLLOW_UP, seq));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(rand_item(ACT_FOLLOW_UP, seq));
            end
        end
        if ($urandom_range(0, 19) != 0)
        begin
            send_item(rand_item(ACT_TX_TS, dreq_seq_held));
        end
        else
        begin
            send_item(rand_item(ACT_TX_TS, 16'($urandom)));
        end
        send_item(rand_item(ACT_DELAY_RESP, 16'($urandom)));
    endtask

    // Extremes of the fields and each corner of the exchange.
    task automatic test_directed();
        // Follow-up matching the reset sequence id before any sync.
        send_item(make_item(ACT_FOLLOW_UP, 16'd0, 1'b0, 32'd0, 30'd0, 32'hFFFF_FFFF,
                            30'd999999999, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
        send_item(make_item(ACT_TX_TS, 16'd1, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd0,
                            30'd0, 64'd0, 1'b1));
        send_item(make_item(ACT_DELAY_RESP, 16'd0, 1'b0, 32'd0, 30'd0, 32'd0, 30'd0,
                            64'h8000_0000_0000_0000, 1'b0));
        // Sync without hardware timestamp, then a follow-up that therefore does not match.
        send_item(make_item(ACT_SYNC, 16'd5, 1'b0, 32'd7, 30'd7, 32'd7, 30'd7, 64'd1, 1'b1));
        send_item(make_item(ACT_FOLLOW_UP, 16'd5, 1'b1, 32'd9, 30'd9, 32'd9, 30'd9, 64'd1,
                            1'b0));
        // Two-step sync, a foreign follow-up, the matching one and a repeat of it.
        send_item(make_item(ACT_SYNC, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 30'd999999999, 32'd0,
                            30'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_item(ACT_FOLLOW_UP, 16'h1234, 1'b1, 32'd3, 30'd3, 32'd3, 30'd3,
                            64'd5, 1'b1));
        send_item(make_item(ACT_FOLLOW_UP, 16'hFFFF, 1'b0, 32'd0, 30'd0, 32'hFFFF_FFFF,
                            30'h3FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
        send_item(make_item(ACT_FOLLOW_UP, 16'hFFFF, 1'b0, 32'd0, 30'd0, 32'h1000_0000,
                            30'd123, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
        // Transmit report with an unissued tag, then the matching one without the present flag.
        send_item(make_item(ACT_TX_TS, dreq_seq_held + 16'd1, 1'b1, 32'd11, 30'd11, 32'd0,
                            30'd0, 64'd0, 1'b0));
        send_item(make_item(ACT_TX_TS, dreq_seq_held, 1'b0, 32'd0, 30'd0, 32'hFFFF_FFFF,
                            30'h3FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_item(ACT_DELAY_RESP, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
                            32'hFFFF_FFFF, 30'd999999999, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
        // One-step sync takes t1 from the same beat.
        send_item(make_item(ACT_SYNC, 16'd0, 1'b1, 32'd0, 30'd0, 32'hFFFF_FFFF,
                            30'd999999999, 64'h8000_0000_0000_0000, 1'b0));
        send_item(make_item(ACT_TX_TS, dreq_seq_held, 1'b1, 32'd100, 30'd500, 32'd0, 30'd0,
                            64'd0, 1'b0));
        send_item(make_item(ACT_DELAY_RESP, 16'd42, 1'b0, 32'd0, 30'd0, 32'd100,
                            30'h3FFF_FFFF, 64'd0, 1'b0));
        // Out-of-range nanoseconds and a correction just below zero.
        send_item(make_item(ACT_SYNC, 16'h00AA, 1'b1, 32'd200, 30'h3FFF_FFFF, 32'd199,
                            30'd999999999, 64'hFFFF_FFFF_FFFF_0001, 1'b0));
        send_item(make_item(ACT_TX_TS, dreq_seq_held, 1'b1, 32'd201, 30'd3, 32'd0, 30'd0,
                            64'd0, 1'b0));
        send_item(make_item(ACT_DELAY_RESP, 16'h00AA, 1'b1, 32'd0, 30'd0, 32'd201, 30'd4,
                            64'hFFFF_FFFF_FFFF_0001, 1'b0));
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        int start_count;
        start_count = items_sent;
        tx_pace = PACE_EAGER;
        hold_request = 1'b1;
        repeat (2) @(posedge clk);
        while (items_sent - start_count < 40)
        begin
            send_exchange();
        end
        tx_pace = PACE_RANDOM;
    endtask

    // Mostly well-formed exchanges, with noise, under changing pacing on both sides.
    task automatic test_random_exchanges();
        int start_count;
        int next_switch;
        start_count = items_sent;
        next_switch = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if (items_sent >= next_switch)
            begin
                tx_pace = ($urandom_range(0, 3) == 0) ? PACE_EAGER : PACE_RANDOM;
                rx_pace = ($urandom_range(0, 3) == 0) ? PACE_EAGER : PACE_RANDOM;
                next_switch = items_sent + 100;
            end
            if ($urandom_range(0, 99) < 75)
            begin
                send_exchange();
            end
            else
            begin
                send_item(rand_item(2'($urandom), 16'($urandom)));
            end
        end
        tx_pace = PACE_RANDOM;
        rx_pace = PACE_RANDOM;
    endtask

    // Result side: random pops, an eager mode and the long hold-off on request.
    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (rx_pace == PACE_EAGER)
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run_len = $urandom_range(1, 12);
                pop <= 1'b1;
                repeat (run_len) @(posedge clk);
                stall_len = pick_gap();
                if (stall_len != 0)
                begin
                    pop <= 1'b0;
                    repeat (stall_len) @(posedge clk);
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Compare every result beat with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (predicted_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result beat, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("send_delay_req", 64'(want.send_delay_req),
                            64'(result.send_delay_req));
                check_field("delay_req_seq", 64'(want.delay_req_seq),
                            64'(result.delay_req_seq));
                check_field("update_valid", 64'(want.update_valid), 64'(result.update_valid));
                check_field("offset_ns", want.offset_ns, result.offset_ns);
                check_field("one_way_delay_ns", want.one_way_delay_ns, result.one_way_delay_ns);
                results_checked++;
                if (want.update_valid)
                begin
                    updates_seen++;
                end
                if (want.send_delay_req)
                begin
                    delay_reqs_seen++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        t1_origin = '0;
        t2_sync_rx = '0;
        t3_req_tx = '0;
        t4_resp = '0;
        sync_corr_acc = '0;
        resp_corr_val = '0;
        sync_seq_held = '0;
        dreq_seq_held = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random_exchanges();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d events and %0d checked results,", items_sent, results_checked);
        $display("including %0d delay requests and %0d offset updates.", delay_reqs_seen,
                 updates_seen);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
